/* rtl/core/dkr_pkg.sv */
// Package for the DFT kernel spectrum refiner: types, codes, field widths
// and the elaboration-time phase trig function. It depends on nothing.
package dkr_pkg;

   localparam int BIN_W  = 16;           // Q1.15 bin parts
   localparam int OUT_W  = 18;           // Q3.15 result parts
   localparam int L_W    = 15;           // refined output index
   localparam int IDX_W  = 12;           // load address field
   localparam int RF_W   = 4;            // refine factor register
   localparam int WT_W   = 5;            // window register
   localparam int NB_W   = 13;           // bins in use register
   localparam int K_W    = 17;           // bin counters, wide enough for any clamp
   localparam int TRIG_W = 18;           // S and CM in Q15, signed
   localparam int PROD_W = 34;           // TRIG_W x BIN_W products
   localparam int NUM_W  = 33;           // rounded dividend magnitude
   localparam int D_W    = 21;           // divisor magnitude
   localparam int ACC_W  = 42;           // term accumulator
   localparam int MC_W   = 35;           // clamped magnitude before output scale
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;
   localparam logic [17:0] INV2PI_Q20 = 18'd166886;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_REFINE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KDIV,
      ST_SETUP,
      ST_COPY_RD,
      ST_COPY_WAIT,
      ST_READ,
      ST_MUL,
      ST_DSTART,
      ST_DWAIT,
      ST_ACC,
      ST_SC1,
      ST_SC2,
      ST_SC3,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] s;
      logic signed [TRIG_W-1:0] cm;
   } trig_pair_type;

   // sin and (cos - 1) of p/r turn in Q15, evaluated only on constants.
   function automatic trig_pair_type trig_calc(int unsigned p, int unsigned r);
      logic [63:0]   num;
      logic [63:0]   rem;
      logic [63:0]   u;
      logic [63:0]   v;
      logic [63:0]   th;
      logic [63:0]   t2;
      logic [63:0]   a;
      logic [63:0]   b;
      logic [63:0]   s30;
      logic [63:0]   c30;
      longint        s;
      longint        c;
      longint        so;
      longint        co;
      int unsigned   q;
      logic          neg;
      trig_pair_type res;
      num = 64'(p) << 30;
      rem = '0;
      u   = '0;
      for (int i = 33; i >= 0; i--) begin
         rem = (rem << 1) | 64'(num[i]);
         if (rem >= 64'(r)) begin
            rem  = rem - 64'(r);
            u[i] = 1'b1;
         end
      end
      q   = 32'(u >> 28);
      v   = u & ((64'd1 << 28) - 64'd1);
      neg = 1'b0;
      if (v > (64'd1 << 27)) begin
         v   = (64'd1 << 28) - v;
         neg = 1'b1;
         q   = q + 1;
      end
      th  = (v * 64'd3373259426) >> 29;
      t2  = (th * th) >> 30;
      a   = (64'd1 << 30) - t2 / 64'd42;
      a   = (64'd1 << 30) - ((t2 * a) >> 30) / 64'd20;
      a   = (64'd1 << 30) - ((t2 * a) >> 30) / 64'd6;
      s30 = (th * a) >> 30;
      b   = (64'd1 << 30) - t2 / 64'd56;
      b   = (64'd1 << 30) - ((t2 * b) >> 30) / 64'd30;
      b   = (64'd1 << 30) - ((t2 * b) >> 30) / 64'd12;
      c30 = (64'd1 << 30) - ((t2 * b) >> 30) / 64'd2;
      s   = longint'((s30 + 64'd16384) >> 15);
      if (neg) s = -s;
      c   = longint'((c30 + 64'd16384) >> 15);
      case (q & 3)
         0: begin so = s;  co = c;  end
         1: begin so = c;  co = -s; end
         2: begin so = -s; co = -c; end
         default: begin so = -c; co = s; end
      endcase
      res.s  = TRIG_W'(so);
      res.cm = TRIG_W'(co - 32768);
      return res;
   endfunction

endpackage

/* rtl/core/dkr_if.sv */
// Handshake channel interfaces of the spectrum refiner: request, response
// and register write. They depend on dkr_pkg for field widths.
interface dkr_req_if;
   import dkr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [IDX_W-1:0]         bin_index;
   logic signed [BIN_W-1:0]  bin_re;
   logic signed [BIN_W-1:0]  bin_im;
   logic [L_W-1:0]           out_index;
   modport source (output valid, op, bin_index, bin_re, bin_im, out_index, input ready);
   modport sink   (input valid, op, bin_index, bin_re, bin_im, out_index, output ready);
endinterface

interface dkr_rsp_if;
   import dkr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  out_re;
   logic signed [OUT_W-1:0]  out_im;
   logic                     clipped;
   modport source (output valid, out_re, out_im, clipped, input ready);
   modport sink   (input valid, out_re, out_im, clipped, output ready);
endinterface

interface dkr_csr_if;
   import dkr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_W-1:0]     index;
   logic [CSR_DAT_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/dkr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing.
module dkr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
endmodule

/* rtl/core/dkr_div.sv */
// Restoring unsigned divider that retires one quotient bit per cycle.
// It depends on nothing; the numerator width sets its latency.
module dkr_div #(
   parameter int NW = 33,
   parameter int DW = 21
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          done_ff,
   output logic [NW-1:0] quo_ff,
   output logic [DW-1:0] rem_ff
);
   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff;
   logic          run_ff;
   logic [DW-1:0] den_ff;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic          ge;

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CW'(1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CW'(NW);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[NW-2:0], ge};
         rem_ff <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      end
   end
endmodule

/* rtl/core/dft_kernel_spectrum_refine.sv */
// Top level of the DFT kernel spectrum refiner: bin store, sequencer and
// datapath. It depends on dkr_pkg, dkr_if, dkr_ram and dkr_div.
//
//   channel  dir  transfer moves
//   req_ch   in   op, bin_index, bin_re, bin_im, out_index
//   rsp_ch   out  out_re, out_im, clipped (one per compute, none per load)
//   csr_ch   in   index, data (register write, always ready)
//
// A load leaves the block idle, so the next request is taken in the following one.
// A compute over T window bins (up to twice the clamped window) runs the index
// division and a setup step, then for each term a read, a multiply, a divider start,
// a divider wait and an accumulate, then the scale steps; a copy reads its one bin
// instead. It is ready for the next request once its result has entered the response
// register. Each term waits on the bit-serial dividers. Reset is synchronous and clears
// control state and presets the CSRs; the bin store is not cleared. A result waits in the
// response register while the block already accepts loads and starts the next compute.
module dft_kernel_spectrum_refine #(
   parameter int MAX_BINS   = 4096,
   parameter int MAX_REFINE = 8,
   parameter int MAX_TERMS  = 16
) (
   input logic        clock,
   input logic        reset,
   dkr_req_if.sink    req_ch,
   dkr_rsp_if.source  rsp_ch,
   dkr_csr_if.sink    csr_ch
);
   import dkr_pkg::*;

   localparam int AW    = $clog2(MAX_BINS);
   localparam int RIW   = (MAX_REFINE > 1) ? $clog2(MAX_REFINE) : 1;
   localparam int TBL_N = 2 ** RIW;

   // Phase table, one entry per refine factor and phase.
   trig_pair_type trig_tbl [TBL_N][TBL_N];
   for (genvar gr = 0; gr < TBL_N; gr++) begin : g_row
      for (genvar gp = 0; gp < TBL_N; gp++) begin : g_col
         if (gr < MAX_REFINE && gp <= gr) begin : g_on
            assign trig_tbl[gr][gp] = trig_calc(gp, gr + 1);
         end else begin : g_off
            assign trig_tbl[gr][gp] = '0;
         end
      end
   end

   // Configuration registers.
   logic [RF_W-1:0] refine_ff;
   logic [WT_W-1:0] window_ff;
   logic [NB_W-1:0] bins_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         refine_ff <= RF_W'(1);
         window_ff <= WT_W'(8);
         bins_ff   <= NB_W'(4096);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_REFINE: refine_ff <= csr_ch.data[RF_W-1:0];
            CSR_WINDOW: window_ff <= csr_ch.data[WT_W-1:0];
            CSR_BINS:   bins_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Out-of-range register values act as the nearest legal one.
   logic [RF_W-1:0] r_eff;
   logic [WT_W-1:0] dt_eff;
   logic [K_W-1:0]  nb_eff;

   always_comb begin
      if (refine_ff == '0)                  r_eff = RF_W'(1);
      else if (int'(refine_ff) > MAX_REFINE) r_eff = RF_W'(MAX_REFINE);
      else                                  r_eff = refine_ff;
      if (int'(window_ff) > MAX_TERMS) dt_eff = WT_W'(MAX_TERMS);
      else                             dt_eff = window_ff;
      if (bins_ff == '0)                  nb_eff = K_W'(1);
      else if (int'(bins_ff) > MAX_BINS)  nb_eff = K_W'(MAX_BINS);
      else                                nb_eff = K_W'(bins_ff);
   end

   state_type state_ff, state_in;

   logic req_fire;
   logic is_load;
   logic rsp_free;
   logic [AW-1:0] rd_addr;
   logic [2*BIN_W-1:0] rd_data;
   logic load_ok;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_load      = (req_ch.op == OP_LOAD);
   assign load_ok      = req_fire && is_load && (int'(req_ch.bin_index) < MAX_BINS);

   dkr_ram #(.WIDTH(2 * BIN_W), .DEPTH(MAX_BINS)) u_store (
      .clock      (clock),
      .wr_en      (load_ok),
      .wr_addr    (AW'(req_ch.bin_index)),
      .wr_data    ({req_ch.bin_re, req_ch.bin_im}),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Working registers of one compute.
   logic [L_W-1:0]   l_ff;
   logic [RF_W-1:0]  r_ff;
   logic [WT_W-1:0]  dt_ff;
   logic [K_W-1:0]   nb_ff;
   logic [RF_W-1:0]  p_ff;
   logic [K_W-1:0]   kstar_ff;
   logic [K_W-1:0]   k_ff;
   logic [K_W-1:0]   kmax_ff;
   logic signed [TRIG_W-1:0] s_ff;
   logic signed [TRIG_W-1:0] cm_ff;
   logic signed [PROD_W-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [D_W:0]      d_ff;
   logic                     neg_re_ff, neg_im_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_im_ff;
   logic [MC_W-1:0]          mr_re_ff, mr_im_ff;
   logic                     sn_re_ff, sn_im_ff;
   logic [MC_W+17:0]         pr_re_ff, pr_im_ff;
   logic signed [OUT_W-1:0]  res_re_ff, res_im_ff;
   logic                     res_clip_ff;
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_re_ff, rsp_im_ff;
   logic                     rsp_clip_ff;

   // Index divider: l / r gives the nearest bin and the phase.
   logic          idx_done;
   logic [L_W-1:0] idx_quo;
   logic [RF_W-1:0] idx_rem;

   dkr_div #(.NW(L_W), .DW(RF_W)) u_idx_div (
      .clock   (clock),
      .reset   (reset),
      .start   (req_fire && !is_load),
      .numer   (req_ch.out_index),
      .denom   (r_eff),
      .done_ff (idx_done),
      .quo_ff  (idx_quo),
      .rem_ff  (idx_rem)
   );

   // Term dividers for the real and imaginary parts.
   logic             term_start;
   logic [NUM_W-1:0] num_re, num_im;
   logic [D_W-1:0]   ud;
   logic             re_done, im_done;
   logic [NUM_W-1:0] q_re, q_im;
   logic [D_W-1:0]   rr_unused_re, rr_unused_im;

   dkr_div #(.NW(NUM_W), .DW(D_W)) u_re_div (
      .clock (clock), .reset (reset), .start (term_start),
      .numer (num_re), .denom (ud),
      .done_ff (re_done), .quo_ff (q_re), .rem_ff (rr_unused_re)
   );

   dkr_div #(.NW(NUM_W), .DW(D_W)) u_im_div (
      .clock (clock), .reset (reset), .start (term_start),
      .numer (num_im), .denom (ud),
      .done_ff (im_done), .quo_ff (q_im), .rem_ff (rr_unused_im)
   );

   // Nearest bin: round(l / r) clamped to the last bin in use.
   logic [K_W-1:0] kraw;
   logic [K_W-1:0] kclamp;
   assign kraw   = K_W'(idx_quo) + K_W'({idx_rem, 1'b0} >= {1'b0, r_ff});
   assign kclamp = (kraw > nb_ff - K_W'(1)) ? nb_ff - K_W'(1) : kraw;

   // Remainder check and window bounds.
   logic signed [K_W+RF_W:0] rnum;
   logic [K_W-1:0] kmin, kmax, ksum;
   assign rnum = $signed({{(K_W+RF_W-L_W+1){1'b0}}, l_ff})
               - $signed({1'b0, kstar_ff * r_ff});
   assign ksum = kstar_ff + K_W'(dt_ff);
   assign kmin = (kstar_ff >= K_W'(dt_ff)) ? kstar_ff - K_W'(dt_ff) : '0;
   assign kmax = (ksum > nb_ff) ? nb_ff : ksum;

   trig_pair_type trig_sel;
   logic [RF_W-1:0] r_m1;
   assign r_m1     = r_ff - RF_W'(1);
   assign trig_sel = trig_tbl[r_m1[RIW-1:0]][p_ff[RIW-1:0]];

   // Term numerators, magnitudes and rounding offset.
   logic signed [PROD_W:0] n_re, n_im;
   logic [PROD_W:0]        an_re, an_im;
   assign n_re   = $signed({p1_ff[PROD_W-1], p1_ff}) - $signed({p2_ff[PROD_W-1], p2_ff});
   assign n_im   = $signed({p3_ff[PROD_W-1], p3_ff}) + $signed({p4_ff[PROD_W-1], p4_ff});
   assign an_re  = n_re[PROD_W] ? -n_re : n_re;
   assign an_im  = n_im[PROD_W] ? -n_im : n_im;
   assign ud     = d_ff[D_W] ? D_W'(-d_ff) : d_ff[D_W-1:0];
   assign num_re = an_re[NUM_W-1:0] + NUM_W'(ud >> 1);
   assign num_im = an_im[NUM_W-1:0] + NUM_W'(ud >> 1);
   assign term_start = (state_ff == ST_DSTART);

   logic signed [K_W+RF_W:0] kr_prod;
   assign kr_prod = $signed({1'b0, k_ff * r_ff});

   assign rd_addr = (state_ff == ST_COPY_RD) ? kstar_ff[AW-1:0] : k_ff[AW-1:0];

   logic signed [BIN_W-1:0] xr, xi;
   assign xr = rd_data[2*BIN_W-1:BIN_W];
   assign xi = rd_data[BIN_W-1:0];

   // Output scale: magnitude clamp keeps every saturating case saturating.
   logic [ACC_W-1:0]     m_re, m_im;
   logic [MC_W-1:0]      mc_re, mc_im;
   logic [MC_W+RF_W-1:0] mrw_re, mrw_im;
   assign m_re   = acc_re_ff[ACC_W-1] ? -acc_re_ff : acc_re_ff;
   assign m_im   = acc_im_ff[ACC_W-1] ? -acc_im_ff : acc_im_ff;
   assign mc_re  = (|m_re[ACC_W-1:MC_W]) ? '1 : m_re[MC_W-1:0];
   assign mc_im  = (|m_im[ACC_W-1:MC_W]) ? '1 : m_im[MC_W-1:0];
   assign mrw_re = mc_re * r_ff;
   assign mrw_im = mc_im * r_ff;

   logic [MC_W+17:0] rnd_re, rnd_im;
   logic [OUT_W-1:0] m2_re, m2_im;
   assign rnd_re = pr_re_ff + (MC_W+18)'(64'd1 << 34);
   assign rnd_im = pr_im_ff + (MC_W+18)'(64'd1 << 34);
   assign m2_re  = rnd_re[MC_W+17:35];
   assign m2_im  = rnd_im[MC_W+17:35];

   logic signed [OUT_W-1:0] sat_re, sat_im;
   logic clip_re, clip_im;
   always_comb begin
      clip_re = 1'b0;
      clip_im = 1'b0;
      if (sn_re_ff) begin
         if (m2_re > OUT_W'(131072)) begin sat_re = OUT_W'(-131072); clip_re = 1'b1; end
         else sat_re = -$signed(m2_re);
      end else begin
         if (m2_re > OUT_W'(131071)) begin sat_re = OUT_W'(131071); clip_re = 1'b1; end
         else sat_re = $signed(m2_re);
      end
      if (sn_im_ff) begin
         if (m2_im > OUT_W'(131072)) begin sat_im = OUT_W'(-131072); clip_im = 1'b1; end
         else sat_im = -$signed(m2_im);
      end else begin
         if (m2_im > OUT_W'(131071)) begin sat_im = OUT_W'(131071); clip_im = 1'b1; end
         else sat_im = $signed(m2_im);
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_fire && !is_load) state_in = ST_KDIV;
         ST_KDIV:      if (idx_done) state_in = ST_SETUP;
         ST_SETUP: begin
            if (rnum == '0)      state_in = ST_COPY_RD;
            else if (kmin < kmax) state_in = ST_READ;
            else                 state_in = ST_SC1;
         end
         ST_COPY_RD:   state_in = ST_COPY_WAIT;
         ST_COPY_WAIT: state_in = ST_OUT;
         ST_READ:      state_in = ST_MUL;
         ST_MUL:       state_in = ST_DSTART;
         ST_DSTART:    state_in = ST_DWAIT;
         ST_DWAIT:     if (re_done && im_done) state_in = ST_ACC;
         ST_ACC:       state_in = (k_ff + K_W'(1) < kmax_ff) ? ST_READ : ST_SC1;
         ST_SC1:       state_in = ST_SC2;
         ST_SC2:       state_in = ST_SC3;
         ST_SC3:       state_in = ST_OUT;
         ST_OUT:       if (rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath registers, loaded by state.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            l_ff  <= req_ch.out_index;
            r_ff  <= r_eff;
            dt_ff <= dt_eff;
            nb_ff <= nb_eff;
         end
         ST_KDIV: begin
            p_ff     <= idx_rem;
            kstar_ff <= kclamp;
         end
         ST_SETUP: begin
            s_ff      <= trig_sel.s;
            cm_ff     <= trig_sel.cm;
            k_ff      <= kmin;
            kmax_ff   <= kmax;
            acc_re_ff <= '0;
            acc_im_ff <= '0;
         end
         ST_COPY_WAIT: begin
            res_re_ff   <= OUT_W'(xr);
            res_im_ff   <= OUT_W'(xi);
            res_clip_ff <= 1'b0;
         end
         ST_MUL: begin
            p1_ff <= s_ff * xr;
            p2_ff <= cm_ff * xi;
            p3_ff <= s_ff * xi;
            p4_ff <= cm_ff * xr;
            d_ff  <= (D_W+1)'($signed({{(K_W+RF_W-L_W+1){1'b0}}, l_ff}) - kr_prod);
         end
         ST_DSTART: begin
            neg_re_ff <= n_re[PROD_W] ^ d_ff[D_W];
            neg_im_ff <= n_im[PROD_W] ^ d_ff[D_W];
         end
         ST_ACC: begin
            acc_re_ff <= neg_re_ff ? acc_re_ff - $signed({{(ACC_W-NUM_W){1'b0}}, q_re})
                                   : acc_re_ff + $signed({{(ACC_W-NUM_W){1'b0}}, q_re});
            acc_im_ff <= neg_im_ff ? acc_im_ff - $signed({{(ACC_W-NUM_W){1'b0}}, q_im})
                                   : acc_im_ff + $signed({{(ACC_W-NUM_W){1'b0}}, q_im});
            k_ff <= k_ff + K_W'(1);
         end
         ST_SC1: begin
            sn_re_ff <= acc_re_ff[ACC_W-1];
            sn_im_ff <= acc_im_ff[ACC_W-1];
            mr_re_ff <= (|mrw_re[MC_W+RF_W-1:MC_W]) ? '1 : mrw_re[MC_W-1:0];
            mr_im_ff <= (|mrw_im[MC_W+RF_W-1:MC_W]) ? '1 : mrw_im[MC_W-1:0];
         end
         ST_SC2: begin
            pr_re_ff <= mr_re_ff * INV2PI_Q20;
            pr_im_ff <= mr_im_ff * INV2PI_Q20;
         end
         ST_SC3: begin
            res_re_ff   <= sat_re;
            res_im_ff   <= sat_im;
            res_clip_ff <= clip_re || clip_im;
         end
         default: ;
      endcase
   end

   // Response register: a finished result waits here for its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_re_ff   <= res_re_ff;
         rsp_im_ff   <= res_im_ff;
         rsp_clip_ff <= res_clip_ff;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.out_re  = rsp_re_ff;
   assign rsp_ch.out_im  = rsp_im_ff;
   assign rsp_ch.clipped = rsp_clip_ff;
endmodule

/* bench/dft_kernel_spectrum_refine_tb.sv */
// Self-checking bench for dft_kernel_spectrum_refine: directed table, then random phases,
// all results compared against typed values or a bit-exact predictor of the interpolation.
// Depends on dkr_pkg, the dkr_*_if interfaces and the refiner top level.
module dft_kernel_spectrum_refine_tb;
   import dkr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBINS       = 4096;
   localparam int NREFINE     = 8;
   localparam int NTERMS      = 16;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int SETTLE      = 40;
   localparam int ITEM_TARGET = 1350;

   typedef struct {
      logic                    op;
      logic [IDX_W-1:0]        idx;
      logic signed [BIN_W-1:0] re;
      logic signed [BIN_W-1:0] im;
      logic [L_W-1:0]          l;
   } refine_req_type;

   typedef struct {
      logic signed [OUT_W-1:0] re;
      logic signed [OUT_W-1:0] im;
      logic                    clip;
   } refined_bin_type;

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   // One directed step: a register write or a request, with an optional typed result.
   typedef struct {
      row_kind_type            kind;
      logic [CSR_IDX_W-1:0]    reg_idx;
      logic [CSR_DAT_W-1:0]    reg_data;
      logic                    op;
      logic [IDX_W-1:0]        idx;
      logic signed [BIN_W-1:0] re;
      logic signed [BIN_W-1:0] im;
      logic [L_W-1:0]          l;
      logic                    typed;
      logic signed [OUT_W-1:0] exp_re;
      logic signed [OUT_W-1:0] exp_im;
      logic                    exp_clip;
   } dir_row_type;

   logic clock;
   logic reset;

   dkr_req_if req_ch ();
   dkr_rsp_if rsp_ch ();
   dkr_csr_if csr_ch ();

   dft_kernel_spectrum_refine uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow copy of the bin store and the three registers.
   logic signed [BIN_W-1:0] bin_re_mem [NBINS];
   logic signed [BIN_W-1:0] bin_im_mem [NBINS];
   bit                      bin_written [NBINS];
   logic [RF_W-1:0]         refine_reg;
   logic [WT_W-1:0]         window_reg;
   logic [NB_W-1:0]         bins_reg;

   refined_bin_type pending_bins[$];
   int  error_count;
   int  items_sent;
   int  cycle_count;
   bit  idle_on;
   bit  stall_request;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Effective register values after the block's clamping rules.
   function automatic void eff_config(output int unsigned rr, output int unsigned dt,
                                      output int unsigned nb);
      rr = (refine_reg == 0) ? 1 : ((refine_reg > NREFINE) ? NREFINE : refine_reg);
      dt = (window_reg > NTERMS) ? NTERMS : window_reg;
      nb = (bins_reg == 0) ? 1 : ((bins_reg > NBINS) ? NBINS : bins_reg);
   endfunction

   // Sine and cosine-minus-one of p/r turn in Q15, built from Q30 Horner series.
   function automatic void phase_sincos(int unsigned p, int unsigned r,
                                        output longint s_q15, output longint cm_q15);
      longint unsigned u, v, th, t2, a, b, s30, c30;
      longint          s, c, so, co;
      int unsigned     quad;
      bit              neg;
      u    = (64'(p) << 30) / 64'(r);
      quad = 32'(u >> 28);
      v    = u & ((64'd1 << 28) - 64'd1);
      neg  = 1'b0;
      // Fold the upper half of each quadrant onto the next one.
      if (v > (64'd1 << 27)) begin
         v    = (64'd1 << 28) - v;
         neg  = 1'b1;
         quad = quad + 1;
      end
      th  = (v * 64'd3373259426) >> 29;
      t2  = (th * th) >> 30;
      a   = (64'd1 << 30) - t2 / 42;
      a   = (64'd1 << 30) - ((t2 * a) >> 30) / 20;
      a   = (64'd1 << 30) - ((t2 * a) >> 30) / 6;
      s30 = (th * a) >> 30;
      b   = (64'd1 << 30) - t2 / 56;
      b   = (64'd1 << 30) - ((t2 * b) >> 30) / 30;
      b   = (64'd1 << 30) - ((t2 * b) >> 30) / 12;
      c30 = (64'd1 << 30) - ((t2 * b) >> 30) / 2;
      s   = longint'((s30 + 64'd16384) >> 15);
      if (neg) s = -s;
      c   = longint'((c30 + 64'd16384) >> 15);
      case (quad % 4)
         0: begin so = s;  co = c;  end
         1: begin so = c;  co = -s; end
         2: begin so = -s; co = -c; end
         default: begin so = -c; co = s; end
      endcase
      s_q15  = so;
      cm_q15 = co - 32768;
   endfunction

   function automatic longint div_half_away(longint n, longint d);
      longint unsigned un, ud, q;
      bit              neg;
      neg = (n < 0) != (d < 0);
      un  = (n < 0) ? -n : n;
      ud  = (d < 0) ? -d : d;
      q   = (un + ud / 2) / ud;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // Scale a kernel sum by R/(2 pi) and saturate to the output width.
   function automatic longint scale_sum(longint acc, int unsigned r, inout bit clip);
      longint unsigned m;
      longint          v;
      bit              neg;
      neg = acc < 0;
      m   = neg ? -acc : acc;
      m   = (m * r * 64'd166886 + (64'd1 << 34)) >> 35;
      if (m > (64'd1 << 20)) m = 64'd1 << 20;
      v = neg ? -longint'(m) : longint'(m);
      if (v > 131071) begin v = 131071; clip = 1'b1; end
      if (v < -131072) begin v = -131072; clip = 1'b1; end
      return v;
   endfunction

   // Window of stored bins that a compute at index l reads.
   function automatic void read_span(int l, output int lo, output int hi);
      int unsigned rr, dt, nb;
      int          kstar;
      eff_config(rr, dt, nb);
      kstar = (2 * l + rr) / (2 * rr);
      if (kstar > nb - 1) kstar = nb - 1;
      if (l - kstar * int'(rr) == 0) begin
         lo = kstar;
         hi = kstar;
      end else begin
         lo = (kstar - int'(dt) < 0) ? 0 : kstar - int'(dt);
         hi = ((kstar + int'(dt)) > int'(nb) ? int'(nb) : kstar + int'(dt)) - 1;
      end
   endfunction

   // Applies one accepted request; returns 1 with the refined bin for a compute.
   function automatic bit refine_step(refine_req_type it, output refined_bin_type res);
      int unsigned rr, dt, nb;
      longint      l, kstar, rnum, sv, cmv, acc_re, acc_im, d, xr, xi;
      int          lo, hi;
      bit          clip;
      res = '{default: '0};
      if (it.op == OP_LOAD) begin
         bin_re_mem[it.idx]  = it.re;
         bin_im_mem[it.idx]  = it.im;
         bin_written[it.idx] = 1'b1;
         return 1'b0;
      end
      eff_config(rr, dt, nb);
      l     = it.l;
      kstar = (2 * l + rr) / (2 * rr);
      if (kstar > nb - 1) kstar = nb - 1;
      rnum = l - kstar * rr;
      if (rnum == 0) begin
         res.re = bin_re_mem[kstar];
         res.im = bin_im_mem[kstar];
         return 1'b1;
      end
      phase_sincos(int'(l % rr), rr, sv, cmv);
      read_span(int'(l), lo, hi);
      acc_re = 0;
      acc_im = 0;
      clip   = 1'b0;
      for (int k = lo; k <= hi; k++) begin
         xr = bin_re_mem[k];
         xi = bin_im_mem[k];
         d  = l - longint'(k) * rr;
         acc_re += div_half_away(sv * xr - cmv * xi, d);
         acc_im += div_half_away(sv * xi + cmv * xr, d);
      end
      res.re   = OUT_W'(scale_sum(acc_re, rr, clip));
      res.im   = OUT_W'(scale_sum(acc_im, rr, clip));
      res.clip = clip;
      return 1'b1;
   endfunction

   // Offers one request after an optional gap; called and returning at a falling edge.
   task automatic send_req(refine_req_type it, bit typed, refined_bin_type typed_res);
      refined_bin_type res;
      int              gap;
      gap = idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.op        = it.op;
      req_ch.bin_index = it.idx;
      req_ch.bin_re    = it.re;
      req_ch.bin_im    = it.im;
      req_ch.out_index = it.l;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (refine_step(it, res)) pending_bins.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   function automatic logic signed [BIN_W-1:0] rand_part();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return BIN_W'($urandom);
      endcase
   endfunction

   // Loads any bin that the coming compute would read but that was never written.
   task automatic fill_span(int l);
      refine_req_type  ld;
      refined_bin_type none;
      int              lo, hi;
      none = '{default: '0};
      read_span(l, lo, hi);
      for (int k = lo; k <= hi; k++) begin
         if (!bin_written[k]) begin
            ld = '{op: OP_LOAD, idx: IDX_W'(k), re: rand_part(), im: rand_part(),
                   l: L_W'($urandom)};
            send_req(ld, 1'b0, none);
         end
      end
   endtask

   // Lets every outstanding result arrive and the block settle before a register write.
   task automatic drain();
      req_ch.valid = 1'b0;
      while (pending_bins.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_REFINE: refine_reg = data[RF_W-1:0];
         CSR_WINDOW: window_reg = data[WT_W-1:0];
         CSR_BINS:   bins_reg   = data[NB_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Result side: a random wait before each transfer when idling is on, plus one long hold-off on request.
   initial begin : result_side
      int              wait_left;
      int              hold_left;
      refined_bin_type exp_bin;
      wait_left = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request && hold_left == 0) begin
            hold_left     = 3000;
            stall_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else if (wait_left > 0) begin
            rsp_ch.ready = 1'b0;
            wait_left--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_bins.size() == 0) begin
               $error("result transfer with nothing expected: out_re=%0d out_im=%0d",
                      rsp_ch.out_re, rsp_ch.out_im);
               error_count++;
            end else begin
               exp_bin = pending_bins.pop_front();
               if (rsp_ch.out_re !== exp_bin.re) begin
                  $error("out_re expected %0d actual %0d", exp_bin.re, rsp_ch.out_re);
                  error_count++;
               end
               if (rsp_ch.out_im !== exp_bin.im) begin
                  $error("out_im expected %0d actual %0d", exp_bin.im, rsp_ch.out_im);
                  error_count++;
               end
               if (rsp_ch.clipped !== exp_bin.clip) begin
                  $error("clipped expected %0d actual %0d", exp_bin.clip, rsp_ch.clipped);
                  error_count++;
               end
            end
            wait_left = idle_on ? $urandom_range(0, 18) : 0;
         end
      end
   end

   // Directed table. A typed result is one that follows from the inputs by inspection;
   // the others come from the predictor.
   dir_row_type dir_rows [] = '{
      // Extreme bin at address 0 and a plain copy of it (refine factor 1).
      '{ROW_ITEM, CSR_REFINE, 0, OP_LOAD, 12'd0, 16'sh7FFF, 16'sh8000, 15'd0, 0, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'd0, 1, 18'sd32767, -18'sd32768, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_LOAD, 12'hFFF, 16'sh8000, 16'sh7FFF, 15'd0, 0, 0, 0, 0},
      // Index past the last bin clamps; phase zero makes the kernel vanish.
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'h7FFF, 1, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'd2, 0, 0, 0, 0},
      // Zero in every register: refine and bins act as 1, the window is empty.
      '{ROW_WRITE, CSR_REFINE, 13'd0, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE, CSR_WINDOW, 13'd0, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE, CSR_BINS, 13'd0, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'd3, 1, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'd0, 1, 18'sd32767, -18'sd32768, 0},
      // All ones in every register: refine and window clamp, bins clamp to the store.
      '{ROW_WRITE, CSR_REFINE, 13'h1FFF, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE, CSR_WINDOW, 13'h1FFF, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE, CSR_BINS, 13'h1FFF, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_LOAD, 12'd1, 16'sh2AAA, -16'sh1555, 15'd0, 0, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'd8, 1, 18'sd10922, -18'sd5461, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'd4, 0, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'd1, 0, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'd7, 0, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'h7FFF, 0, 0, 0, 0},
      // A small odd factor with few bins, and an index beyond them.
      '{ROW_WRITE, CSR_REFINE, 13'd3, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE, CSR_WINDOW, 13'd1, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_WRITE, CSR_BINS, 13'd16, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'd2, 0, 0, 0, 0},
      '{ROW_ITEM, CSR_REFINE, 0, OP_COMPUTE, 12'd0, 0, 0, 15'd47, 0, 0, 0, 0}
   };

   initial begin : stimulus
      refine_req_type  it;
      refined_bin_type typed_res;
      int unsigned     rr, dt, nb;
      int              phase_items;
      int              phase_no;
      int              l_top;
      bit              in_write;

      reset         = 1'b1;
      error_count   = 0;
      items_sent    = 0;
      cycle_count   = 0;
      idle_on       = 1'b0;
      stall_request = 1'b0;
      refine_reg    = RF_W'(1);
      window_reg    = WT_W'(8);
      bins_reg      = NB_W'(4096);
      foreach (bin_written[i]) bin_written[i] = 1'b0;
      req_ch.valid     = 1'b0;
      req_ch.op        = OP_LOAD;
      req_ch.bin_index = '0;
      req_ch.bin_re    = '0;
      req_ch.bin_im    = '0;
      req_ch.out_index = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = CSR_REFINE;
      csr_ch.data      = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed part: register writes wait for the block to go quiet first.
      in_write = 1'b0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_WRITE) begin
            if (!in_write) drain();
            in_write = 1'b1;
            write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
         end else begin
            in_write = 1'b0;
            it = '{op: dir_rows[i].op, idx: dir_rows[i].idx, re: dir_rows[i].re,
                   im: dir_rows[i].im, l: dir_rows[i].l};
            typed_res = '{re: dir_rows[i].exp_re, im: dir_rows[i].exp_im,
                          clip: dir_rows[i].exp_clip};
            if (it.op == OP_COMPUTE) fill_span(int'(it.l));
            send_req(it, dir_rows[i].typed, typed_res);
         end
      end

      // Random phases, each with its own register setting and idling pattern.
      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         drain();
         write_reg(CSR_REFINE, CSR_DAT_W'($urandom_range(0, 8191)));
         write_reg(CSR_WINDOW, ($urandom_range(0, 4) == 0) ? CSR_DAT_W'($urandom_range(0, 8191))
                                                           : CSR_DAT_W'($urandom_range(0, 4)));
         write_reg(CSR_BINS, ($urandom_range(0, 3) == 0) ? CSR_DAT_W'($urandom_range(0, 8191))
                                                         : CSR_DAT_W'($urandom_range(1, 64)));
         idle_on = $urandom_range(0, 2) != 0;
         // In the third phase the result side stops for a long while so the block backs up.
         if (phase_no == 2) stall_request = 1'b1;
         eff_config(rr, dt, nb);
         phase_items = $urandom_range(40, 80);
         repeat (phase_items) begin
            it.re = rand_part();
            it.im = rand_part();
            it.l  = L_W'($urandom);
            if ($urandom_range(0, 1) == 0) begin
               it.op  = OP_LOAD;
               it.idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
                                                    : IDX_W'($urandom_range(0, nb - 1));
            end else begin
               it.op  = OP_COMPUTE;
               it.idx = IDX_W'($urandom);
               l_top  = nb * rr + rr;
               if (l_top > 32767) l_top = 32767;
               if ($urandom_range(0, 3) != 0) it.l = L_W'($urandom_range(0, l_top));
               fill_span(int'(it.l));
            end
            send_req(it, 1'b0, typed_res);
         end
         phase_no++;
      end

      req_ch.valid = 1'b0;
      while (pending_bins.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/dkr_pkg.sv
rtl/core/dkr_if.sv
rtl/core/dkr_ram.sv
rtl/core/dkr_div.sv
rtl/core/dft_kernel_spectrum_refine.sv
bench/dft_kernel_spectrum_refine_tb.sv
